### src/tpre_pkg.sv
// Package for the TIFF predictor and RGBA expand block.
// Holds shared types, codes and the default colour map depth; no dependencies.
package tpre_pkg;

    localparam int PALETTE_ENTRIES_DEFAULT = 256;

    typedef enum logic [1:0] {
        FMT_GRAY    = 2'd0,
        FMT_PALETTE = 2'd1,
        FMT_RGB     = 2'd2,
        FMT_RGBA    = 2'd3
    } pixel_format_t;

    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_PREDICTOR_ON = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_SAMPLE        = 1'b0,
        CMD_PALETTE_WRITE = 1'b1
    } command_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_word_t;

    function automatic logic [2:0] samples_for_format(pixel_format_t fmt);
        logic [2:0] count;
        case (fmt)
            FMT_RGB:  count = 3'd3;
            FMT_RGBA: count = 3'd4;
            default:  count = 3'd1;
        endcase
        return count;
    endfunction

endpackage

### src/tpre_in_if.sv
// Input channel of the TIFF predictor and RGBA expand block.
// Carries sample beats and palette write beats; no dependencies.
interface tpre_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  sample;
    logic        start_of_image;
    logic [7:0]  palette_index;
    logic [15:0] palette_red;
    logic [15:0] palette_green;
    logic [15:0] palette_blue;

    modport source (
        output valid, command, sample, start_of_image,
               palette_index, palette_red, palette_green, palette_blue,
        input  ready
    );

    modport sink (
        input  valid, command, sample, start_of_image,
               palette_index, palette_red, palette_green, palette_blue,
        output ready
    );
endinterface

### src/tpre_out_if.sv
// Output channel of the TIFF predictor and RGBA expand block.
// Carries one RGBA8 pixel per beat; no dependencies.
interface tpre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;

    modport source (
        output valid, red, green, blue, alpha, row_end,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, alpha, row_end,
        output ready
    );
endinterface

### src/tpre_palette_ram.sv
// Colour map memory: one write port and one registered read port.
// Depends on tpre_pkg for the colour word type.
module tpre_palette_ram
    import tpre_pkg::*;
#(
    parameter int ENTRIES = PALETTE_ENTRIES_DEFAULT,
    parameter int ADDR_W  = $clog2(ENTRIES)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  colour_word_t      wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output colour_word_t      rd_data
);

    colour_word_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/tiff_predictor_rgba_expand_unit.sv
// Top level of the TIFF horizontal predictor decoder with RGBA8 expansion.
// Depends on tpre_pkg, tpre_in_if, tpre_out_if and tpre_palette_ram.
//
//   Channel   Direction  Beat contents
//   samples   in         sample byte or palette entry write
//   pixels    out        RGBA8 pixel with end-of-row flag
//   write_*   in         configuration register write, no handshake
//
// One input beat is taken every cycle; a pixel appears in the cycle after its
// last sample. The palette lookup uses the registered read port of the colour
// map, which sits in the same stage as the result register. Reset clears the
// configuration and the pixel position; the colour map is not cleared.
// When the result register is full and not taken, the input is stalled.
module tiff_predictor_rgba_expand_unit
    import tpre_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        write_enable,
    input  logic [1:0]  write_index,
    input  logic [15:0] write_data,
    tpre_in_if.sink     samples,
    tpre_out_if.source  pixels
);

    localparam int         ADDR_W      = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

    pixel_format_t fmt_reg;
    logic          pred_reg;
    logic [15:0]   width_reg;

    logic [1:0]    chan_reg;
    logic [1:0]    chan_next;
    logic [15:0]   col_reg;
    logic [15:0]   col_next;
    logic [7:0]    prev_reg [4];
    logic [7:0]    partial_reg [3];
    logic          out_valid_reg;
    logic          out_valid_next;

    logic [7:0]    red_reg;
    logic [7:0]    green_reg;
    logic [7:0]    blue_reg;
    logic [7:0]    alpha_reg;
    logic          row_end_reg;
    logic          lookup_reg;
    logic          oob_reg;

    logic          stage_en;
    logic          accept;
    logic          take_sample;
    logic          pal_write;
    logic          finish;
    logic [15:0]   col_base;
    logic [1:0]    chan_base;
    logic [2:0]    count;
    logic [1:0]    chan;
    logic [7:0]    recon;
    logic          done;
    logic [15:0]   width_eff;
    logic [16:0]   col_inc;
    logic          last;
    logic [7:0]    red_calc;
    logic [7:0]    green_calc;
    logic [7:0]    blue_calc;
    logic [7:0]    alpha_calc;
    colour_word_t  pal_wdata;
    colour_word_t  pal_rdata;

    assign stage_en       = !out_valid_reg || pixels.ready;
    assign samples.ready  = stage_en;
    assign accept         = samples.valid && stage_en;
    assign take_sample    = accept && (command_t'(samples.command) == CMD_SAMPLE);
    assign pal_write      = accept && (command_t'(samples.command) == CMD_PALETTE_WRITE)
                            && ({1'b0, samples.palette_index} < ENTRY_LIMIT);
    assign finish         = take_sample && done;

    assign pal_wdata.red   = samples.palette_red[15:8];
    assign pal_wdata.green = samples.palette_green[15:8];
    assign pal_wdata.blue  = samples.palette_blue[15:8];

    always_comb
    begin
        col_base  = samples.start_of_image ? 16'd0 : col_reg;
        chan_base = samples.start_of_image ? 2'd0 : chan_reg;
        count     = samples_for_format(fmt_reg);
        chan      = ({1'b0, chan_base} >= count) ? 2'd0 : chan_base;
        if (pred_reg && (col_base != 16'd0))
        begin
            recon = samples.sample + prev_reg[chan];
        end
        else
        begin
            recon = samples.sample;
        end
        done      = (({1'b0, chan} + 3'd1) >= count);
        width_eff = (width_reg == 16'd0) ? 16'd1 : width_reg;
        col_inc   = {1'b0, col_base} + 17'd1;
        last      = (col_inc >= {1'b0, width_eff});
        if (done)
        begin
            chan_next = 2'd0;
            col_next  = last ? 16'd0 : col_inc[15:0];
        end
        else
        begin
            chan_next = chan + 2'd1;
            col_next  = col_base;
        end
    end

    always_comb
    begin
        alpha_calc = 8'd255;
        case (fmt_reg)
            FMT_RGB:
            begin
                red_calc   = partial_reg[0];
                green_calc = partial_reg[1];
                blue_calc  = recon;
            end
            FMT_RGBA:
            begin
                red_calc   = partial_reg[0];
                green_calc = partial_reg[1];
                blue_calc  = partial_reg[2];
                alpha_calc = recon;
            end
            default:
            begin
                red_calc   = recon;
                green_calc = recon;
                blue_calc  = recon;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stage_en)
        begin
            out_valid_next = finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_GRAY;
            pred_reg      <= 1'b0;
            width_reg     <= 16'd1;
            chan_reg      <= 2'd0;
            col_reg       <= 16'd0;
            prev_reg      <= '{default: 8'd0};
            partial_reg   <= '{default: 8'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (write_enable)
            begin
                case (cfg_index_t'(write_index))
                    REG_PIXEL_FORMAT: fmt_reg   <= pixel_format_t'(write_data[1:0]);
                    REG_PREDICTOR_ON: pred_reg  <= write_data[0];
                    REG_IMAGE_WIDTH:  width_reg <= write_data;
                    default:          ;
                endcase
            end
            if (take_sample)
            begin
                chan_reg       <= chan_next;
                col_reg        <= col_next;
                prev_reg[chan] <= recon;
                if (!done && (chan != 2'd3))
                begin
                    partial_reg[chan] <= recon;
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en && finish)
        begin
            red_reg     <= red_calc;
            green_reg   <= green_calc;
            blue_reg    <= blue_calc;
            alpha_reg   <= alpha_calc;
            row_end_reg <= last;
            lookup_reg  <= (fmt_reg == FMT_PALETTE);
            oob_reg     <= ({1'b0, recon} >= ENTRY_LIMIT);
        end
    end

    tpre_palette_ram #(
        .ENTRIES (PALETTE_ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_write),
        .wr_addr (samples.palette_index[ADDR_W-1:0]),
        .wr_data (pal_wdata),
        .rd_en   (finish && (fmt_reg == FMT_PALETTE)),
        .rd_addr (recon[ADDR_W-1:0]),
        .rd_data (pal_rdata)
    );

    always_comb
    begin
        pixels.valid   = out_valid_reg;
        pixels.alpha   = alpha_reg;
        pixels.row_end = row_end_reg;
        if (lookup_reg)
        begin
            if (oob_reg)
            begin
                pixels.red   = 8'd0;
                pixels.green = 8'd0;
                pixels.blue  = 8'd0;
            end
            else
            begin
                pixels.red   = pal_rdata.red;
                pixels.green = pal_rdata.green;
                pixels.blue  = pal_rdata.blue;
            end
        end
        else
        begin
            pixels.red   = red_reg;
            pixels.green = green_reg;
            pixels.blue  = blue_reg;
        end
    end

endmodule

### tb/tb.sv
// Testbench for tiff_predictor_rgba_expand_unit: random and directed sample and palette beats,
// checked against a behavioral model of predictor undo and RGBA8 expansion.
// Depends on tpre_pkg, tpre_in_if, tpre_out_if and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import tpre_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD = 300;

    typedef struct {
        command_t    command;
        logic [7:0]  sample;
        logic        start_of_image;
        logic [7:0]  palette_index;
        logic [15:0] palette_red;
        logic [15:0] palette_green;
        logic [15:0] palette_blue;
    } sample_beat_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
    } rgba_pixel_t;

    logic        clk;
    logic        rst_n;
    logic        write_enable;
    logic [1:0]  write_index;
    logic [15:0] write_data;

    tpre_in_if  samples_if();
    tpre_out_if pixels_if();

    tiff_predictor_rgba_expand_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .samples      (samples_if),
        .pixels       (pixels_if)
    );

    sample_beat_t pending_beats[$];
    rgba_pixel_t  expected_pixels[$];

    pixel_format_t cfg_format;
    logic          cfg_predict;
    logic [15:0]   cfg_width;

    logic [1:0]   chan_pos;
    logic [15:0]  pixel_col;
    logic [7:0]   prev_samples[4];
    logic [7:0]   partial_samples[3];
    colour_word_t palette_rgb[256];

    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_left;
    bit          beat_taken;
    bit          calm;
    bit          stall_request;
    rgba_pixel_t want;

    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic expand_beat(input sample_beat_t b);
        logic [7:0]  v;
        logic [2:0]  c;
        logic [2:0]  n;
        logic [16:0] eff_width;
        logic        last;
        rgba_pixel_t px;
        if (b.command == CMD_PALETTE_WRITE)
        begin
            palette_rgb[b.palette_index] = {b.palette_red[15:8], b.palette_green[15:8],
                                            b.palette_blue[15:8]};
            return;
        end
        if (b.start_of_image)
        begin
            chan_pos = 2'd0;
            pixel_col = 16'd0;
        end
        case (cfg_format)
            FMT_RGB:  n = 3'd3;
            FMT_RGBA: n = 3'd4;
            default:  n = 3'd1;
        endcase
        c = {1'b0, chan_pos};
        if (c >= n)
        begin
            c = 3'd0;
        end
        v = b.sample;
        if (cfg_predict && pixel_col != 16'd0)
        begin
            v = v + prev_samples[c[1:0]];
        end
        prev_samples[c[1:0]] = v;
        if (c + 3'd1 < n)
        begin
            partial_samples[c[1:0]] = v;
            chan_pos = c[1:0] + 2'd1;
            return;
        end
        px.alpha = 8'hFF;
        case (cfg_format)
            FMT_PALETTE:
            begin
                {px.red, px.green, px.blue} = palette_rgb[v];
            end
            FMT_RGB:
            begin
                px.red = partial_samples[0];
                px.green = partial_samples[1];
                px.blue = v;
            end
            FMT_RGBA:
            begin
                px.red = partial_samples[0];
                px.green = partial_samples[1];
                px.blue = partial_samples[2];
                px.alpha = v;
            end
            default:
            begin
                px.red = v;
                px.green = v;
                px.blue = v;
            end
        endcase
        eff_width = (cfg_width == 16'd0) ? 17'd1 : {1'b0, cfg_width};
        last = ({1'b0, pixel_col} + 17'd1 >= eff_width);
        pixel_col = last ? 16'd0 : pixel_col + 16'd1;
        chan_pos = 2'd0;
        px.row_end = last;
        expected_pixels.push_back(px);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_value,
                               input logic [7:0] got_value);
        if (got_value !== exp_value)
        begin
            $error("pixel %s: expected %0d, got %0d", name, exp_value, got_value);
            error_count++;
        end
    endtask

    task automatic push_sample(input logic [7:0] value, input logic sof);
        sample_beat_t b;
        b.command = CMD_SAMPLE;
        b.sample = value;
        b.start_of_image = sof;
        b.palette_index = 8'($urandom_range(0, 255));
        b.palette_red = 16'($urandom_range(0, 65535));
        b.palette_green = 16'($urandom_range(0, 65535));
        b.palette_blue = 16'($urandom_range(0, 65535));
        pending_beats.push_back(b);
    endtask

    task automatic push_palette(input logic [7:0] idx, input logic [15:0] r,
                                input logic [15:0] g, input logic [15:0] bl);
        sample_beat_t b;
        b.command = CMD_PALETTE_WRITE;
        b.sample = 8'($urandom_range(0, 255));
        b.start_of_image = 1'($urandom_range(0, 1));
        b.palette_index = idx;
        b.palette_red = r;
        b.palette_green = g;
        b.palette_blue = bl;
        pending_beats.push_back(b);
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || expected_pixels.size() != 0 || samples_if.valid)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        write_enable <= 1'b1;
        write_index <= idx;
        write_data <= value;
        @(negedge clk);
        write_enable <= 1'b0;
        case (idx)
            REG_PIXEL_FORMAT: cfg_format = pixel_format_t'(value[1:0]);
            REG_PREDICTOR_ON: cfg_predict = value[0];
            default:          cfg_width = value;
        endcase
    endtask

    task automatic set_mode(input pixel_format_t fmt, input logic pred, input logic [15:0] width);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, {14'd0, fmt});
        write_reg(REG_PREDICTOR_ON, {15'd0, pred});
        write_reg(REG_IMAGE_WIDTH, width);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && samples_if.valid && samples_if.ready)
        begin
            expand_beat(pending_beats.pop_front());
            beat_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            samples_if.valid <= 1'b0;
        end
        else if (!samples_if.valid || beat_taken)
        begin
            beat_taken = 1'b0;
            if (send_gap != 0)
            begin
                send_gap--;
                samples_if.valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                samples_if.valid <= 1'b1;
                samples_if.command <= pending_beats[0].command;
                samples_if.sample <= pending_beats[0].sample;
                samples_if.start_of_image <= pending_beats[0].start_of_image;
                samples_if.palette_index <= pending_beats[0].palette_index;
                samples_if.palette_red <= pending_beats[0].palette_red;
                samples_if.palette_green <= pending_beats[0].palette_green;
                samples_if.palette_blue <= pending_beats[0].palette_blue;
                send_gap = pick_gap(calm);
            end
            else
            begin
                samples_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_request)
        begin
            hold_left = LONG_HOLD;
            stall_request = 1'b0;
        end
        if (!rst_n)
        begin
            pixels_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            pixels_if.ready <= 1'b0;
        end
        else if (recv_gap != 0)
        begin
            recv_gap--;
            pixels_if.ready <= 1'b0;
        end
        else
        begin
            pixels_if.ready <= 1'b1;
            recv_gap = pick_gap(calm);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pixels_if.valid && pixels_if.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel beat with no expected pixel: r %0d g %0d b %0d a %0d",
                       pixels_if.red, pixels_if.green, pixels_if.blue, pixels_if.alpha);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("red", want.red, pixels_if.red);
                check_field("green", want.green, pixels_if.green);
                check_field("blue", want.blue, pixels_if.blue);
                check_field("alpha", want.alpha, pixels_if.alpha);
                check_field("row_end", {7'd0, want.row_end}, {7'd0, pixels_if.row_end});
            end
        end
    end

    initial
    begin
        int unsigned rand_items;
        int unsigned phase_len;
        int unsigned phase_no;
        int unsigned r;
        int unsigned pos;
        int unsigned spp;
        logic [15:0] width;
        pixel_format_t fmt;

        rst_n = 1'b0;
        write_enable = 1'b0;
        write_index = REG_PIXEL_FORMAT;
        write_data = 16'd0;
        samples_if.valid = 1'b0;
        samples_if.command = CMD_SAMPLE;
        samples_if.sample = 8'd0;
        samples_if.start_of_image = 1'b0;
        samples_if.palette_index = 8'd0;
        samples_if.palette_red = 16'd0;
        samples_if.palette_green = 16'd0;
        samples_if.palette_blue = 16'd0;
        pixels_if.ready = 1'b0;
        cfg_format = FMT_GRAY;
        cfg_predict = 1'b0;
        cfg_width = 16'd1;
        chan_pos = 2'd0;
        pixel_col = 16'd0;
        for (int i = 0; i < 4; i++)
        begin
            prev_samples[i] = 8'd0;
        end
        for (int i = 0; i < 3; i++)
        begin
            partial_samples[i] = 8'd0;
        end
        cycle_count = 0;
        error_count = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;
        beat_taken = 1'b0;
        calm = 1'b0;
        stall_request = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The colour map is not cleared by reset, so every entry is loaded first.
        for (int i = 0; i < 256; i++)
        begin
            push_palette(8'(i), 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
        end
        push_palette(8'd0, 16'hFFFF, 16'h00FF, 16'hFF00);
        push_palette(8'd255, 16'h0000, 16'hFFFF, 16'h80FF);

        set_mode(FMT_GRAY, 1'b0, 16'd1);
        push_sample(8'd0, 1'b1);
        push_sample(8'd255, 1'b0);
        push_sample(8'hA5, 1'b0);

        set_mode(FMT_PALETTE, 1'b0, 16'd2);
        push_sample(8'd0, 1'b1);
        push_sample(8'd255, 1'b0);
        push_palette(8'd7, 16'h1234, 16'hABCD, 16'h5678);
        push_sample(8'd7, 1'b0);

        set_mode(FMT_RGB, 1'b1, 16'd3);
        push_sample(8'd200, 1'b1);
        push_sample(8'd10, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd100, 1'b0);
        push_palette(8'd9, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_sample(8'd255, 1'b0);
        push_sample(8'd1, 1'b0);

        // Three samples of an RGBA pixel, then a switch to RGB leaves the channel
        // position past the end of a pixel.
        set_mode(FMT_RGBA, 1'b1, 16'd2);
        push_sample(8'd1, 1'b1);
        push_sample(8'd2, 1'b0);
        push_sample(8'd3, 1'b0);
        push_sample(8'd4, 1'b0);
        push_sample(8'd250, 1'b0);
        push_sample(8'd251, 1'b0);
        push_sample(8'd252, 1'b0);

        set_mode(FMT_RGB, 1'b1, 16'd0);
        push_sample(8'd9, 1'b0);
        push_sample(8'd8, 1'b0);
        push_sample(8'd7, 1'b0);

        // A wide row cut short by a narrower width.
        set_mode(FMT_GRAY, 1'b1, 16'hFFFF);
        push_sample(8'd16, 1'b1);
        push_sample(8'd16, 1'b0);
        push_sample(8'd16, 1'b0);
        set_mode(FMT_GRAY, 1'b1, 16'd2);
        push_sample(8'd1, 1'b0);
        push_sample(8'd1, 1'b0);

        rand_items = 0;
        phase_no = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            fmt = pixel_format_t'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                width = 16'($urandom_range(1, 6));
            end
            else if (r < 80)
            begin
                width = 16'($urandom_range(7, 40));
            end
            else if (r < 88)
            begin
                width = 16'd0;
            end
            else if (r < 94)
            begin
                width = 16'hFFFF;
            end
            else
            begin
                width = 16'($urandom_range(1, 65535));
            end
            set_mode(fmt, 1'($urandom_range(0, 1)), width);
            calm = ($urandom_range(0, 3) == 0);
            if (phase_no == 1)
            begin
                calm = 1'b1;
                stall_request = 1'b1;
            end
            spp = (fmt == FMT_RGB) ? 3 : (fmt == FMT_RGBA) ? 4 : 1;
            phase_len = $urandom_range(20, 120);
            pos = 0;
            for (int k = 0; k < phase_len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    push_palette(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)));
                end
                else if (r < 7)
                begin
                    push_sample(8'($urandom_range(0, 255)), 1'b1);
                    pos = 1 % spp;
                end
                else
                begin
                    push_sample(8'($urandom_range(0, 255)),
                                (k == 0) || (pos == 0 && $urandom_range(0, 49) == 0));
                    pos = (k == 0) ? 1 % spp : (pos + 1) % spp;
                end
                rand_items++;
            end
            phase_no++;
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_pixels.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
